@@ rtl/stq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and address helper for the sorted timer queue.
package stq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int TIME_W   = 32;
    localparam int NUM_W    = 16;
    localparam int KIND_W   = 3;
    localparam int OP_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_ADD   = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        K_FIRED  = 3'd0,
        K_STATUS = 3'd1,
        K_ADDED  = 3'd2,
        K_FULL   = 3'd3,
        K_STEP   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIRE,
        ST_STEP_END,
        ST_INS,
        ST_RESP
    } t_state;

    // Request from the sequencer to the expiry store.
    typedef struct packed {
        logic              wr_en;
        logic [CNT_W-1:0]  wr_lidx;
        logic [TIME_W-1:0] wr_data;
        logic [CNT_W-1:0]  rd_lidx;
        logic              adv_en;
        logic [CNT_W-1:0]  adv_by;
    } t_store_req;

    // Result of the shared compare/subtract unit.
    typedef struct packed {
        logic              eq;
        logic              gt;
        logic [TIME_W-1:0] diff;
    } t_cmp;

    // Map a position relative to the queue head onto a physical slot.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] lidx);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(lidx);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/stq_alu.sv @@
`timescale 1ns / 1ps
// Shared compare and subtract unit used by the scan, fire, insert and status steps.
module stq_alu (
    input  logic [stq_pkg::TIME_W-1:0] i_a,
    input  logic [stq_pkg::TIME_W-1:0] i_b,
    output stq_pkg::t_cmp              o_cmp
);

    always_comb begin
        o_cmp.eq   = (i_a == i_b);
        o_cmp.gt   = (i_a > i_b);
        o_cmp.diff = i_a - i_b;
    end

endmodule

@@ rtl/stq_store.sv @@
`timescale 1ns / 1ps
// Circular expiry store: one read and one write per cycle, head advance on expiry.
module stq_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  stq_pkg::t_store_req        i_req,
    output logic [stq_pkg::TIME_W-1:0] o_rd_data
);

    logic [stq_pkg::TIME_W-1:0] r_mem [stq_pkg::CAPACITY];
    logic [stq_pkg::IDX_W-1:0]  r_head;

    assign o_rd_data = r_mem[stq_pkg::phys(r_head, i_req.rd_lidx)];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[stq_pkg::phys(r_head, i_req.wr_lidx)] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (i_req.adv_en) begin
            r_head <= stq_pkg::phys(r_head, i_req.adv_by);
        end
    end

endmodule

@@ rtl/sorted_timer_queue.sv @@
`timescale 1ns / 1ps
// Top level: command sequencer, time and counters, result register.
//
// Sorted timer queue with one request at a time. A request is taken while
// the block is idle, even if the previous result still waits in the output
// register. An add walks the stored timers later than the new expiry, one
// entry moved per cycle. A tick or set-time makes two passes over the timers
// at or before the new time: one pass counts them and a second pass numbers
// and reports the fired ones. Both passes and the insert walk use a single
// compare/subtract unit over the one read port of the expiry store. Output
// stalls hold the fire pass and the result steps.
module sorted_timer_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [stq_pkg::OP_W-1:0]     i_opcode,
    input  logic [stq_pkg::TIME_W-1:0]   i_operand_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [stq_pkg::KIND_W-1:0]   o_kind,
    output logic [stq_pkg::NUM_W-1:0]    o_timer_number,
    output logic [stq_pkg::TIME_W-1:0]   o_now_time,
    output logic [stq_pkg::TIME_W-1:0]   o_ticks_left,
    output logic                         o_none_pending,
    output logic                         o_last
);

    stq_pkg::t_state            r_state, n_state;
    logic [stq_pkg::TIME_W-1:0] r_now, n_now;
    logic [stq_pkg::NUM_W-1:0]  r_fin, n_fin;
    logic [stq_pkg::CNT_W-1:0]  r_count, n_count;
    logic [stq_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [stq_pkg::CNT_W-1:0]  r_gone, n_gone;
    logic [stq_pkg::TIME_W-1:0] r_val, n_val;
    stq_pkg::t_kind             r_kind, n_kind;

    logic                       r_ovalid;
    logic [stq_pkg::KIND_W-1:0] r_okind;
    logic [stq_pkg::NUM_W-1:0]  r_onum;
    logic [stq_pkg::TIME_W-1:0] r_onow;
    logic [stq_pkg::TIME_W-1:0] r_oleft;
    logic                       r_onone;
    logic                       r_olast;

    logic                       s_accept;
    logic                       s_slot;
    logic                       s_emit;
    stq_pkg::t_kind             s_ekind;
    logic [stq_pkg::TIME_W-1:0] s_eleft;
    logic                       s_enone;
    logic                       s_elast;
    logic [stq_pkg::NUM_W-1:0]  s_next_num;

    stq_pkg::t_store_req        s_req;
    logic [stq_pkg::TIME_W-1:0] s_rd_data;
    logic [stq_pkg::TIME_W-1:0] s_alu_b;
    stq_pkg::t_cmp              s_cmp;

    stq_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (s_req),
        .o_rd_data (s_rd_data)
    );

    stq_alu u_alu (
        .i_a   (s_rd_data),
        .i_b   (s_alu_b),
        .o_cmp (s_cmp)
    );

    assign o_in_ready = (r_state == stq_pkg::ST_IDLE);
    assign s_accept   = i_in_valid && o_in_ready;
    assign s_slot     = !r_ovalid || i_out_ready;
    assign s_next_num = r_fin + 16'd1;
    assign s_alu_b    = (r_state == stq_pkg::ST_INS) ? r_val : r_now;

    always_comb begin
        n_state = r_state;
        n_now   = r_now;
        n_fin   = r_fin;
        n_count = r_count;
        n_idx   = r_idx;
        n_gone  = r_gone;
        n_val   = r_val;
        n_kind  = r_kind;

        s_emit  = 1'b0;
        s_ekind = stq_pkg::K_STEP;
        s_eleft = '0;
        s_enone = (r_count == '0);
        s_elast = 1'b1;

        s_req.wr_en   = 1'b0;
        s_req.wr_lidx = r_idx;
        s_req.wr_data = r_val;
        s_req.rd_lidx = r_idx;
        s_req.adv_en  = 1'b0;
        s_req.adv_by  = r_gone;

        unique case (r_state)
            stq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_idx = '0;
                    n_val = i_operand_value;
                    unique case (stq_pkg::t_op'(i_opcode))
                        stq_pkg::OP_TICK: begin
                            n_now   = r_now + 32'd1;
                            n_state = stq_pkg::ST_SCAN;
                        end
                        stq_pkg::OP_SET: begin
                            n_now   = i_operand_value;
                            n_state = stq_pkg::ST_SCAN;
                        end
                        stq_pkg::OP_ADD: begin
                            if (r_count >= stq_pkg::CNT_W'(stq_pkg::CAPACITY)) begin
                                n_kind  = stq_pkg::K_FULL;
                                n_state = stq_pkg::ST_RESP;
                            end else begin
                                n_idx   = r_count;
                                n_state = stq_pkg::ST_INS;
                            end
                        end
                        stq_pkg::OP_QUERY: begin
                            n_kind  = stq_pkg::K_STATUS;
                            n_state = stq_pkg::ST_RESP;
                        end
                        default: begin
                            n_state = stq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            stq_pkg::ST_SCAN: begin
                // Count the sorted prefix at or before the new time.
                if ((r_idx < r_count) && !s_cmp.gt) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_gone  = r_idx;
                    n_idx   = '0;
                    n_state = stq_pkg::ST_FIRE;
                end
            end
            stq_pkg::ST_FIRE: begin
                if (r_idx < r_gone) begin
                    if (s_cmp.eq) begin
                        if (s_slot) begin
                            s_emit  = 1'b1;
                            s_ekind = stq_pkg::K_FIRED;
                            s_enone = (r_gone == r_count);
                            s_elast = 1'b0;
                            n_fin   = s_next_num;
                            n_idx   = r_idx + 1'b1;
                        end
                    end else begin
                        // Drop a missed timer but still count it.
                        n_fin = s_next_num;
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    s_req.adv_en = 1'b1;
                    n_count      = r_count - r_gone;
                    n_state      = stq_pkg::ST_STEP_END;
                end
            end
            stq_pkg::ST_STEP_END: begin
                if (s_slot) begin
                    s_emit  = 1'b1;
                    s_ekind = stq_pkg::K_STEP;
                    n_state = stq_pkg::ST_IDLE;
                end
            end
            stq_pkg::ST_INS: begin
                s_req.rd_lidx = r_idx - 1'b1;
                s_req.wr_en   = 1'b1;
                if ((r_idx != '0) && s_cmp.gt) begin
                    // Move the later entry up one place.
                    s_req.wr_data = s_rd_data;
                    n_idx         = r_idx - 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                    n_kind  = stq_pkg::K_ADDED;
                    n_state = stq_pkg::ST_RESP;
                end
            end
            stq_pkg::ST_RESP: begin
                s_req.rd_lidx = '0;
                if (s_slot) begin
                    s_emit  = 1'b1;
                    s_ekind = r_kind;
                    if ((r_kind == stq_pkg::K_STATUS) && (r_count != '0)) begin
                        s_eleft = s_cmp.diff;
                    end
                    n_state = stq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stq_pkg::ST_IDLE;
            r_now   <= '0;
            r_fin   <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_gone  <= '0;
            r_kind  <= stq_pkg::K_STEP;
        end else begin
            r_state <= n_state;
            r_now   <= n_now;
            r_fin   <= n_fin;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_gone  <= n_gone;
            r_kind  <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (s_emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_okind <= s_ekind;
            r_onum  <= s_next_num;
            r_onow  <= r_now;
            r_oleft <= s_eleft;
            r_onone <= s_enone;
            r_olast <= s_elast;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_kind         = r_okind;
    assign o_timer_number = r_onum;
    assign o_now_time     = r_onow;
    assign o_ticks_left   = r_oleft;
    assign o_none_pending = r_onone;
    assign o_last         = r_olast;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stq_pkg::CNT_W'(stq_pkg::CAPACITY))
        else $error("pending count above capacity");

    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == stq_pkg::K_FIRED) |-> !o_last)
        else $error("fired result marked last");

    a_gone_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stq_pkg::ST_FIRE) |-> (r_gone <= r_count))
        else $error("expired count above pending count");

    a_step_frees_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stq_pkg::ST_FIRE) && (r_idx >= r_gone)
        |=> (r_state == stq_pkg::ST_STEP_END) && (r_count == $past(r_count - r_gone)))
        else $error("store not shrunk after time step");
`endif

endmodule

@@ tb/sorted_timer_queue_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sorted timer queue: directed and random requests.
module sorted_timer_queue_tb;

    typedef struct {
        stq_pkg::t_kind             kind;
        logic [stq_pkg::NUM_W-1:0]  timer_number;
        logic [stq_pkg::TIME_W-1:0] now_time;
        logic [stq_pkg::TIME_W-1:0] ticks_left;
        logic                       none_pending;
        logic                       last_flag;
    } t_timer_event;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [stq_pkg::OP_W-1:0]     i_opcode;
    logic [stq_pkg::TIME_W-1:0]   i_operand_value;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic [stq_pkg::KIND_W-1:0]   o_kind;
    logic [stq_pkg::NUM_W-1:0]    o_timer_number;
    logic [stq_pkg::TIME_W-1:0]   o_now_time;
    logic [stq_pkg::TIME_W-1:0]   o_ticks_left;
    logic                         o_none_pending;
    logic                         o_last;

    // Shadow of the block state, advanced on every accepted request.
    logic [stq_pkg::TIME_W-1:0]   shadow_now;
    logic [stq_pkg::TIME_W-1:0]   shadow_expiry [stq_pkg::CAPACITY];
    int                           shadow_count;
    logic [stq_pkg::NUM_W-1:0]    shadow_finished;

    t_timer_event                 expected_events[$];
    int                           error_count;
    int                           sender_idle_pct;
    int                           receiver_stall_pct;
    bit                           receiver_hold_off;

    sorted_timer_queue u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_operand_value(i_operand_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_timer_number (o_timer_number),
        .o_now_time     (o_now_time),
        .o_ticks_left   (o_ticks_left),
        .o_none_pending (o_none_pending),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("sorted_timer_queue_tb NOT OK");
        $finish;
    end

    function automatic void push_event(stq_pkg::t_kind kind,
                                       logic [stq_pkg::NUM_W-1:0] number,
                                       logic [stq_pkg::TIME_W-1:0] left, logic last_flag);
        t_timer_event ev;
        ev.kind         = kind;
        ev.timer_number = number;
        ev.now_time     = shadow_now;
        ev.ticks_left   = left;
        ev.none_pending = (shadow_count == 0);
        ev.last_flag    = last_flag;
        expected_events.push_back(ev);
    endfunction

    // Drop or fire every timer at or before the new time, then close the step.
    function automatic void expire_timers();
        int                        gone;
        logic [stq_pkg::NUM_W-1:0] fired_numbers[$];
        gone = 0;
        while (gone < shadow_count && shadow_expiry[gone] <= shadow_now) begin
            shadow_finished++;
            if (shadow_expiry[gone] == shadow_now) begin
                fired_numbers.push_back(shadow_finished);
            end
            gone++;
        end
        for (int i = 0; i + gone < shadow_count; i++) begin
            shadow_expiry[i] = shadow_expiry[i + gone];
        end
        shadow_count -= gone;
        foreach (fired_numbers[i]) begin
            push_event(stq_pkg::K_FIRED, fired_numbers[i], '0, 1'b0);
        end
        push_event(stq_pkg::K_STEP, stq_pkg::NUM_W'(shadow_finished + 1'b1), '0, 1'b1);
    endfunction

    function automatic void predict_request(stq_pkg::t_op op,
                                            logic [stq_pkg::TIME_W-1:0] value);
        int                        pos;
        logic [stq_pkg::NUM_W-1:0] next_number;
        next_number = stq_pkg::NUM_W'(shadow_finished + 1'b1);
        case (op)
            stq_pkg::OP_TICK: begin
                shadow_now = shadow_now + 1'b1;
                expire_timers();
            end
            stq_pkg::OP_SET: begin
                shadow_now = value;
                expire_timers();
            end
            stq_pkg::OP_ADD: begin
                if (shadow_count >= stq_pkg::CAPACITY) begin
                    push_event(stq_pkg::K_FULL, next_number, '0, 1'b1);
                end else begin
                    // equal expiries stay behind the ones already stored
                    pos = shadow_count;
                    while (pos > 0 && shadow_expiry[pos - 1] > value) begin
                        shadow_expiry[pos] = shadow_expiry[pos - 1];
                        pos--;
                    end
                    shadow_expiry[pos] = value;
                    shadow_count++;
                    push_event(stq_pkg::K_ADDED, next_number, '0, 1'b1);
                end
            end
            default: begin
                push_event(stq_pkg::K_STATUS, next_number,
                           (shadow_count > 0) ? shadow_expiry[0] - shadow_now : '0, 1'b1);
            end
        endcase
    endfunction

    function automatic void compare_field(string field,
                                          logic [stq_pkg::TIME_W-1:0] expected_value,
                                          logic [stq_pkg::TIME_W-1:0] actual_value);
        if (expected_value !== actual_value) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, expected_value, actual_value);
            error_count++;
        end
    endfunction

    // Result side: check each accepted result and pick the next ready value.
    always @(posedge i_clk) begin
        t_timer_event ev;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d number %0h",
                             $time, o_kind, o_timer_number);
                    error_count++;
                end else begin
                    ev = expected_events.pop_front();
                    compare_field("kind", stq_pkg::TIME_W'(ev.kind),
                                  stq_pkg::TIME_W'(o_kind));
                    compare_field("timer_number", stq_pkg::TIME_W'(ev.timer_number),
                                  stq_pkg::TIME_W'(o_timer_number));
                    compare_field("now_time", ev.now_time, o_now_time);
                    compare_field("ticks_left", ev.ticks_left, o_ticks_left);
                    compare_field("none_pending", stq_pkg::TIME_W'(ev.none_pending),
                                  stq_pkg::TIME_W'(o_none_pending));
                    compare_field("last", stq_pkg::TIME_W'(ev.last_flag),
                                  stq_pkg::TIME_W'(o_last));
                end
            end
            if (receiver_hold_off) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Hold the result side off for a counted number of cycles.
    task automatic hold_off_receiver(int cycles);
        receiver_hold_off = 1'b1;
        repeat (cycles) @(posedge i_clk);
        receiver_hold_off = 1'b0;
    endtask

    task automatic send_request(stq_pkg::t_op op, logic [stq_pkg::TIME_W-1:0] value);
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_operand_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        predict_request(op, value);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_events.size() != 0);
    endtask

    task automatic test_directed();
        send_request(stq_pkg::OP_QUERY, 32'hFFFF_FFFF);
        send_request(stq_pkg::OP_TICK, 32'h0);
        send_request(stq_pkg::OP_ADD, 32'd5);
        send_request(stq_pkg::OP_ADD, 32'd5);
        send_request(stq_pkg::OP_ADD, 32'd3);
        send_request(stq_pkg::OP_ADD, 32'd0);            // already in the past
        send_request(stq_pkg::OP_QUERY, 32'h0);
        send_request(stq_pkg::OP_TICK, 32'hFFFF_FFFF);   // drop the past timer silently
        send_request(stq_pkg::OP_TICK, 32'h0);
        send_request(stq_pkg::OP_SET, 32'd5);            // two equal timers fire in add order
        send_request(stq_pkg::OP_QUERY, 32'h0);
        send_request(stq_pkg::OP_ADD, 32'hFFFF_FFFF);
        send_request(stq_pkg::OP_SET, 32'hFFFF_FFFE);
        send_request(stq_pkg::OP_TICK, 32'h0);
        send_request(stq_pkg::OP_ADD, 32'd3);
        send_request(stq_pkg::OP_TICK, 32'h0);           // wrap to zero keeps the timer at 3
        send_request(stq_pkg::OP_QUERY, 32'h0);
        send_request(stq_pkg::OP_SET, 32'd3);
        send_request(stq_pkg::OP_ADD, 32'd100);
        send_request(stq_pkg::OP_SET, 32'd50);
        send_request(stq_pkg::OP_SET, 32'd20);           // move time backward
        send_request(stq_pkg::OP_SET, 32'd100);
        wait_for_results();
    endtask

    task automatic test_full_store();
        send_request(stq_pkg::OP_SET, 32'd1000);
        repeat (stq_pkg::CAPACITY) send_request(stq_pkg::OP_ADD, 32'd2000);
        send_request(stq_pkg::OP_ADD, 32'h0);
        send_request(stq_pkg::OP_QUERY, 32'h0);
        send_request(stq_pkg::OP_SET, 32'd2000);         // every stored timer fires at once
        // descending values force the longest insert walk
        for (int i = stq_pkg::CAPACITY - 1; i >= 0; i--) begin
            send_request(stq_pkg::OP_ADD, 32'd3000 + i);
        end
        send_request(stq_pkg::OP_ADD, 32'hFFFF_FFFF);
        send_request(stq_pkg::OP_SET, 32'd3007);
        send_request(stq_pkg::OP_SET, 32'hFFFF_FFFF);
        wait_for_results();
    endtask

    task automatic send_random_request();
        stq_pkg::t_op               op;
        logic [stq_pkg::TIME_W-1:0] value;
        int                         pick;
        int                         choice;
        pick   = $urandom_range(99);
        choice = $urandom_range(9);
        value  = $urandom;
        if (pick < 35) begin
            op = stq_pkg::OP_ADD;
            if (choice <= 5) begin
                value = shadow_now + $urandom_range(0, 12);
            end else if (choice == 6) begin
                value = shadow_now - $urandom_range(1, 5);
            end else if (choice == 8 && shadow_count > 0) begin
                value = shadow_expiry[$urandom_range(shadow_count - 1)];
            end else if (choice == 9) begin
                value = 32'hFFFF_FFFF - $urandom_range(3);
            end
        end else if (pick < 65) begin
            op = stq_pkg::OP_TICK;
        end else if (pick < 85) begin
            op = stq_pkg::OP_SET;
            if (choice <= 4) begin
                value = (shadow_count > 0) ? shadow_expiry[$urandom_range(shadow_count - 1)]
                                           : shadow_now + $urandom_range(0, 8);
            end else if (choice <= 6) begin
                value = shadow_now + $urandom_range(0, 30);
            end else if (choice == 8) begin
                value = shadow_now - $urandom_range(0, 10);
            end else if (choice == 9) begin
                value = 32'hFFFF_FFFF - $urandom_range(4);
            end
        end else begin
            op = stq_pkg::OP_QUERY;
        end
        send_request(op, value);
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_random_request();
        wait_for_results();
    endtask

    // Hold the result side off while requests keep coming, then wait for every result.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        fork
            hold_off_receiver(400);
        join_none
        repeat (40) send_random_request();
        wait_for_results();
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_opcode           <= stq_pkg::OP_TICK;
        i_operand_value    <= '0;
        shadow_now          = '0;
        shadow_count        = 0;
        shadow_finished     = '0;
        sender_idle_pct     = 0;
        receiver_stall_pct  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_store();
        test_random_traffic(70, 0, 0);
        test_random_traffic(70, 59, 0);
        test_random_traffic(70, 0, 59);
        test_random_traffic(70, 12, 12);
        test_backpressure();

        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("sorted_timer_queue_tb OK");
        end else begin
            $display("sorted_timer_queue_tb NOT OK");
        end
        $finish;
    end

endmodule
